[rtl/dertok_pkg.sv]
// ----------------------------------------------------------------------------
// DER TLV tokenizer package
// Shared types and constants of the DER TLV stream tokenizer.
// ----------------------------------------------------------------------------
package dertok_pkg;

  // Default values of the top-level parameters.
  localparam int MAX_LENGTH_BYTES_DEF = 4;
  localparam int OID_WIDTH_DEF        = 32;

  // Width of the long-form length byte counter (holds up to 15).
  localparam int LEN_CNT_W = 4;

  // Depth of the queue between the parser and the result serializer.
  localparam int QUEUE_DEPTH = 4;

  // Results that one input byte can cause at most.
  localparam int MAX_RESULTS = 3;

  // Universal tags that get checked or decoded.
  localparam logic [7:0] TAG_BOOLEAN    = 8'h01;
  localparam logic [7:0] TAG_BIT_STRING = 8'h03;
  localparam logic [7:0] TAG_OID        = 8'h06;
  localparam int         TAG_CONSTRUCTED_BIT = 5;

  // Largest unused-bit count of a bit string.
  localparam logic [7:0] MAX_UNUSED_BITS = 8'd7;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_CONTENT = 2'd1,
    KIND_OID     = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_LEN_WIDE     = 3'd1,
    ERR_BOOL_LEN     = 3'd2,
    ERR_UNUSED_BITS  = 3'd3,
    ERR_OID_OVERFLOW = 3'd4
  } err_e;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  tag;
    logic [31:0] value;
    err_e        error_code;
    logic        element_end;
    logic        last;
  } result_t;

  // All results caused by one input byte; cnt is 1 to 3.
  typedef struct packed {
    logic [1:0]                   cnt;
    result_t [MAX_RESULTS-1:0]    res;
  } bundle_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

[rtl/dertok_front.sv]
// ----------------------------------------------------------------------------
// DER TLV tokenizer parser
// Takes one byte per transfer, tracks the TLV phase and builds the results
// that the byte causes as one bundle for the queue.
// ----------------------------------------------------------------------------
module dertok_front import dertok_pkg::*; #(
  parameter int MAX_LENGTH_BYTES = MAX_LENGTH_BYTES_DEF,
  parameter int OID_WIDTH        = OID_WIDTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  input  logic     accept_i,
  input  in_item_t item_i,
  output logic     push_o,
  output bundle_t  bundle_o
);

  localparam int OidBits = (OID_WIDTH < 32) ? OID_WIDTH : 32;
  localparam logic [OidBits-1:0] Forty  = OidBits'(40);
  localparam logic [OidBits-1:0] Eighty = OidBits'(80);

  typedef enum logic [1:0] {
    PH_TAG,
    PH_LEN,
    PH_LENB,
    PH_CONTENT
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [7:0]           tag_q, tag_d;
  logic [31:0]          rem_q, rem_d;
  logic [LEN_CNT_W-1:0] lbl_q, lbl_d;
  logic                 first_q, first_d;
  logic [OidBits-1:0]   acc_q, acc_d;
  logic                 oid_first_q, oid_first_d;
  logic                 err_q, err_d;
  logic                 oid_en_q;

  phase_e               ph_cur;
  logic                 err_cur;
  logic [7:0]           b;
  logic                 hdr_go;
  logic [31:0]          hdr_len;
  logic                 fail_go;
  err_e                 fail_code;
  logic [31:0]          len_new;
  logic [LEN_CNT_W-1:0] lbl_new;
  logic                 endnow;
  logic                 oid;
  logic                 complete;
  logic [OidBits-1:0]   acc_new;
  logic [OidBits-1:0]   arc_hi;
  logic [OidBits-1:0]   arc_lo;
  bundle_t              bun;

  function automatic result_t mk(kind_e k, logic [7:0] t, logic [31:0] v, err_e c,
                                 logic e);
    result_t r;
    r.kind        = k;
    r.tag         = t;
    r.value       = v;
    r.error_code  = c;
    r.element_end = e;
    r.last        = 1'b0;
    return r;
  endfunction

  always_comb begin
    phase_d     = phase_q;
    tag_d       = tag_q;
    rem_d       = rem_q;
    lbl_d       = lbl_q;
    first_d     = first_q;
    acc_d       = acc_q;
    oid_first_d = oid_first_q;
    err_d       = err_q;
    ph_cur      = phase_q;
    err_cur     = err_q;
    b           = item_i.byte_in;
    hdr_go      = 1'b0;
    hdr_len     = '0;
    fail_go     = 1'b0;
    fail_code   = ERR_NONE;
    len_new     = '0;
    lbl_new     = '0;
    endnow      = (rem_q <= 32'd1);
    oid         = (tag_q == TAG_OID) && oid_en_q;
    complete    = 1'b0;
    acc_new     = acc_q;
    arc_hi      = '0;
    arc_lo      = '0;
    bun         = '0;

    // A restart drops all element state and any latched error.
    if (item_i.restart) begin
      phase_d     = PH_TAG;
      tag_d       = '0;
      rem_d       = '0;
      lbl_d       = '0;
      first_d     = 1'b1;
      acc_d       = '0;
      oid_first_d = 1'b1;
      err_d       = 1'b0;
      ph_cur      = PH_TAG;
      err_cur     = 1'b0;
    end

    if (!err_cur) begin
      unique case (ph_cur)
        PH_TAG: begin
          tag_d   = b;
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          if (!b[7]) begin
            hdr_go  = 1'b1;
            hdr_len = {25'd0, b[6:0]};
          end else if (b[6:0] > 7'(MAX_LENGTH_BYTES)) begin
            fail_go   = 1'b1;
            fail_code = ERR_LEN_WIDE;
          end else if (b[6:0] == 7'd0) begin
            // Indefinite form is taken as an empty element.
            hdr_go = 1'b1;
          end else begin
            lbl_d   = b[LEN_CNT_W-1:0];
            rem_d   = '0;
            phase_d = PH_LENB;
          end
        end
        PH_LENB: begin
          if (rem_q[31:24] != 8'd0) begin
            fail_go   = 1'b1;
            fail_code = ERR_LEN_WIDE;
          end else begin
            len_new = {rem_q[23:0], b};
            lbl_new = (lbl_q != '0) ? lbl_q - LEN_CNT_W'(1) : '0;
            rem_d   = len_new;
            lbl_d   = lbl_new;
            if (lbl_new == '0) begin
              hdr_go  = 1'b1;
              hdr_len = len_new;
            end
          end
        end
        PH_CONTENT: begin
          if (tag_q == TAG_BIT_STRING && first_q && b > MAX_UNUSED_BITS) begin
            fail_go   = 1'b1;
            fail_code = ERR_UNUSED_BITS;
          end else if (oid && acc_q[OidBits-1 -: 7] != 7'd0) begin
            fail_go   = 1'b1;
            fail_code = ERR_OID_OVERFLOW;
          end else begin
            if (oid) begin
              acc_new = {acc_q[OidBits-8:0], b[6:0]};
            end
            complete = oid && (!b[7] || endnow);
            first_d  = 1'b0;
            rem_d    = endnow ? 32'd0 : rem_q - 32'd1;
            bun.res[0] = mk(KIND_CONTENT, tag_q, {24'd0, b}, ERR_NONE,
                            endnow && !complete);
            bun.cnt    = 2'd1;
            if (complete) begin
              if (oid_first_q) begin
                // The first subidentifier carries the first two arcs.
                if (acc_new >= Eighty) begin
                  arc_hi = OidBits'(2);
                  arc_lo = acc_new - Eighty;
                end else if (acc_new >= Forty) begin
                  arc_hi = OidBits'(1);
                  arc_lo = acc_new - Forty;
                end else begin
                  arc_hi = '0;
                  arc_lo = acc_new;
                end
                bun.res[1]  = mk(KIND_OID, tag_q, 32'(arc_hi), ERR_NONE, 1'b0);
                bun.res[2]  = mk(KIND_OID, tag_q, 32'(arc_lo), ERR_NONE, endnow);
                bun.cnt     = 2'd3;
                oid_first_d = 1'b0;
              end else begin
                bun.res[1] = mk(KIND_OID, tag_q, 32'(acc_new), ERR_NONE, endnow);
                bun.cnt    = 2'd2;
              end
              acc_d = '0;
            end else begin
              acc_d = acc_new;
            end
            if (endnow) begin
              phase_d = PH_TAG;
            end
          end
        end
        default: phase_d = PH_TAG;
      endcase

      if (hdr_go) begin
        if (tag_q == TAG_BOOLEAN && hdr_len != 32'd1) begin
          fail_go   = 1'b1;
          fail_code = ERR_BOOL_LEN;
        end else if (hdr_len == 32'd0 || tag_q[TAG_CONSTRUCTED_BIT]) begin
          // Empty and constructed elements end at their header.
          phase_d    = PH_TAG;
          bun.res[0] = mk(KIND_HEADER, tag_q, hdr_len, ERR_NONE, 1'b1);
          bun.cnt    = 2'd1;
        end else begin
          phase_d     = PH_CONTENT;
          rem_d       = hdr_len;
          first_d     = 1'b1;
          acc_d       = '0;
          oid_first_d = 1'b1;
          bun.res[0]  = mk(KIND_HEADER, tag_q, hdr_len, ERR_NONE, 1'b0);
          bun.cnt     = 2'd1;
        end
      end

      if (fail_go) begin
        bun.res[0] = mk(KIND_ERROR, tag_q, 32'd0, fail_code, 1'b0);
        bun.cnt    = 2'd1;
        err_d      = 1'b1;
        phase_d    = PH_TAG;
      end
    end

    if (bun.cnt != 2'd0) begin
      bun.res[bun.cnt - 2'd1].last = 1'b1;
    end
  end

  assign push_o   = accept_i && (bun.cnt != 2'd0);
  assign bundle_o = bun;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_TAG;
      tag_q       <= '0;
      rem_q       <= '0;
      lbl_q       <= '0;
      first_q     <= 1'b1;
      acc_q       <= '0;
      oid_first_q <= 1'b1;
      err_q       <= 1'b0;
      oid_en_q    <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        oid_en_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        phase_q     <= phase_d;
        tag_q       <= tag_d;
        rem_q       <= rem_d;
        lbl_q       <= lbl_d;
        first_q     <= first_d;
        acc_q       <= acc_d;
        oid_first_q <= oid_first_d;
        err_q       <= err_d;
      end
    end
  end

  // An error is always the only result of its byte.
  a_err_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && bundle_o.res[0].kind == KIND_ERROR |-> bundle_o.cnt == 2'd1)
    else $error("error result shares its bundle");

  // A latched error silences every byte without restart.
  a_err_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q && !item_i.restart |-> !push_o)
    else $error("result after latched error");

  // Parsing a length never runs with an empty byte counter.
  a_lenb_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_LENB && !err_q |-> lbl_q != '0)
    else $error("length byte phase with zero count");

endmodule

[rtl/dertok_queue.sv]
// ----------------------------------------------------------------------------
// DER TLV tokenizer queue
// Short FIFO of result bundles between the parser and the serializer.
// ----------------------------------------------------------------------------
module dertok_queue import dertok_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t push_data_i,
  input  logic    pop_i,
  output bundle_t head_o,
  output qstat_t  stat_o
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);

  bundle_t         mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [PtrW:0]   count_q;

  assign stat_o.full  = (count_q == (PtrW+1)'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (PtrW+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (PtrW+1)'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("pop from empty queue");

  a_no_empty_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> push_data_i.cnt != 2'd0)
    else $error("bundle without results queued");

endmodule

[rtl/dertok_back.sv]
// ----------------------------------------------------------------------------
// DER TLV tokenizer serializer
// Sends the results of the queued bundles one per transfer through an
// output register.
// ----------------------------------------------------------------------------
module dertok_back import dertok_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  bundle_t head_i,
  input  qstat_t  stat_i,
  output logic    pop_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_data_o
);

  logic [1:0] idx_q;
  logic       out_valid_q;
  result_t    out_q;
  logic       load;
  logic       at_end;

  assign load   = (!out_valid_q || !out_stall_i) && !stat_i.empty;
  assign at_end = (idx_q == head_i.cnt - 2'd1);
  assign pop_o  = load && at_end;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= head_i.res[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= at_end ? 2'd0 : idx_q + 2'd1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stat_i.empty |-> idx_q < head_i.cnt)
    else $error("result index beyond bundle");

  a_pop_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> head_i.res[idx_q].last)
    else $error("bundle retired before its last result");

  a_mid_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && !at_end |-> !head_i.res[idx_q].last)
    else $error("last flag inside a bundle");

endmodule

[rtl/der_tlv_stream_tokenizer.sv]
// ----------------------------------------------------------------------------
// DER TLV stream tokenizer
// Splits an ASN.1 DER byte stream into header, content, OID component and
// error results.
// ----------------------------------------------------------------------------
// The block takes one DER byte per input transfer and sustains one byte per
// clock cycle while the queue is not full: the parser classifies each byte
// combinationally and hands the zero to three results it causes, as one
// bundle, to a four-entry queue. The serializer behind the queue sends one
// result per output transfer, so a byte that causes three results (the
// first OID subidentifier) occupies the output for three transfers; bytes
// without results (tags, leading length bytes) cost no output transfers.
// Input stall rises only while the queue is full. In an idle block the
// first result of a byte is written into a queue entry and then loaded
// into the output register before it is offered on the output.
// ----------------------------------------------------------------------------
module der_tlv_stream_tokenizer import dertok_pkg::*; #(
  parameter int MAX_LENGTH_BYTES = MAX_LENGTH_BYTES_DEF,
  parameter int OID_WIDTH        = OID_WIDTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  // Configuration: OID decode enable.
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  // Input byte stream.
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  // Result stream.
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output result_t  out_data_o
);

  logic    accept;
  logic    push;
  logic    pop;
  bundle_t push_data;
  bundle_t head;
  qstat_t  qstat;

  // A byte is taken whenever the queue has room for its bundle; the queue
  // decouples the parser from stalls on the result side.
  assign in_stall_o = qstat.full;
  assign accept     = in_valid_i && !qstat.full;

  // Front end: tag, length and content parsing, checks and OID rebuilding.
  dertok_front #(
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES),
    .OID_WIDTH       (OID_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .item_i     (in_data_i),
    .push_o     (push),
    .bundle_o   (push_data)
  );

  // Bundle queue between the two halves.
  dertok_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (qstat)
  );

  // Back end: one result per transfer from the queue head.
  dertok_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .stat_i     (qstat),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Results only ever come from a byte that was taken.
  a_push_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> accept)
    else $error("bundle pushed without an input transfer");

  // With a filled queue the output register cannot stay empty.
  a_output_fed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !qstat.empty && !out_valid_o |=> out_valid_o)
    else $error("output idle while results wait");

  // Any result the block shows names a valid error code for its kind.
  a_err_code_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind != KIND_ERROR |-> out_data_o.error_code == ERR_NONE)
    else $error("error code on a non-error result");

endmodule
